>>> src/csmg_pkg.sv
// shared types, constants and the crc byte update for the crc16 seeded mask generator
`timescale 1ns / 1ps

package csmg_pkg;

  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] MAX_MASK_WORDS = 6'd63;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd16;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic KIND_CRC = 1'b0;
  localparam logic KIND_MASK = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        value;
    logic [COUNT_W-1:0] word_index;
    logic               last;
  } out_word_t;

  typedef enum logic {
    BK_IDLE,
    BK_WORDS
  } back_state_e;

  // msb-first crc-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/csmg_in_if.sv
// byte input channel
`timescale 1ns / 1ps

interface csmg_in_if;
  logic               valid;
  logic               ready;
  csmg_pkg::in_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/csmg_out_if.sv
// result output channel
`timescale 1ns / 1ps

interface csmg_out_if;
  logic                valid;
  logic                ready;
  csmg_pkg::out_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/csmg_front.sv
// front part: running crc over incoming bytes, pushes the checksum on the last byte
`timescale 1ns / 1ps

module csmg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  csmg_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [15:0]      crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic        accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign crc_next   = csmg_pkg::crc_byte(crc_q, in_i.data.data_byte);

  assign push_o = accept && in_i.data.last_byte;
  assign crc_o  = crc_next;

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      // region closes: start over from zero
      crc_d = in_i.data.last_byte ? 16'h0000 : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

>>> src/csmg_crc_fifo.sv
// short queue of finished checksums between front and back
`timescale 1ns / 1ps

module csmg_crc_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [15:0] push_data_i,
  input  logic        pop_i,
  output logic [15:0] pop_data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = csmg_pkg::FIFO_PTR_W;
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] Depth = CntW'(csmg_pkg::FIFO_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(csmg_pkg::FIFO_DEPTH - 1);

  logic [15:0]     mem_q [csmg_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == Depth);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> src/csmg_back.sv
// back part: gives the checksum, seeds the mask generator and bursts out the mask words
`timescale 1ns / 1ps

module csmg_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [csmg_pkg::COUNT_W-1:0]   word_count_i,
  input  logic                           empty_i,
  input  logic [15:0]                    crc_i,
  output logic                           pop_o,
  csmg_out_if.source                     out_o
);

  localparam int unsigned CW = csmg_pkg::COUNT_W;

  csmg_pkg::back_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  csmg_pkg::out_word_t   out_data_q, out_data_d;
  logic [31:0]           lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]         cnt_q, cnt_d, idx_q, idx_d;
  logic [CW-1:0]         count_sat;
  logic                  load;
  logic                  last_word;
  logic [31:0]           t_mix, lo_next, hi_next;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // output slot free this cycle or being emptied
  assign load      = !out_valid_q || out_o.ready;
  assign count_sat = (word_count_i > csmg_pkg::MAX_MASK_WORDS) ?
                     csmg_pkg::MAX_MASK_WORDS : word_count_i;
  assign last_word = ((idx_q + CW'(1)) == cnt_q);

  // shift-xor generator step
  assign t_mix   = {hi_q[0], lo_q[31:1]} ^ {lo_q[19:0], 12'h000};
  assign hi_next = {hi_q[30:0], lo_q[0]};
  assign lo_next = t_mix ^ {20'h00000, t_mix[31:20]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csmg_pkg::BK_IDLE: begin
        if (load && !empty_i && (count_sat != '0)) begin
          state_d = csmg_pkg::BK_WORDS;
        end
      end
      csmg_pkg::BK_WORDS: begin
        if (load && last_word) begin
          state_d = csmg_pkg::BK_IDLE;
        end
      end
      default: state_d = csmg_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    unique case (state_q)
      csmg_pkg::BK_IDLE: begin
        if (load && !empty_i) begin
          pop_o                 = 1'b1;
          out_valid_d           = 1'b1;
          out_data_d.kind       = csmg_pkg::KIND_CRC;
          out_data_d.value      = {16'h0000, crc_i};
          out_data_d.word_index = '0;
          out_data_d.last       = (count_sat == '0);
          lo_d                  = {crc_i, crc_i};
          hi_d                  = {crc_i, crc_i};
          cnt_d                 = count_sat;
          idx_d                 = '0;
        end
      end
      csmg_pkg::BK_WORDS: begin
        if (load) begin
          out_valid_d           = 1'b1;
          out_data_d.kind       = csmg_pkg::KIND_MASK;
          out_data_d.value      = lo_next;
          out_data_d.word_index = idx_q;
          out_data_d.last       = last_word;
          lo_d                  = lo_next;
          hi_d                  = hi_next;
          idx_d                 = idx_q + CW'(1);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csmg_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
  end

endmodule

>>> src/crc16_seeded_mask_generator.sv
// top level of the crc16 seeded mask generator
`timescale 1ns / 1ps

// takes one byte per cycle when not stalled and keeps a running crc-16/xmodem over the
// region; on the word marked last_byte the checksum goes into a two-entry queue and the
// crc restarts from zero. the back part then sends the checksum word, seeds its two
// 32-bit generator words with the checksum repeated into both halves and sends
// mask_word_count mask words, one per cycle, the final one marked last. a region
// ending in byte n therefore yields 1 + mask_word_count output words at one per cycle
// once the output is taken. the front keeps taking bytes during a burst and stalls
// only while two finished checksums wait in the queue. mask_word_count may only be
// changed while the block is idle.
module crc16_seeded_mask_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  csmg_in_if.sink                      in_i,
  csmg_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [csmg_pkg::COUNT_W-1:0] cfg_wdata_i
);

  logic [csmg_pkg::COUNT_W-1:0] word_count_q;
  logic                         push;
  logic [15:0]                  push_crc;
  logic                         pop;
  logic [15:0]                  pop_crc;
  logic                         full;
  logic                         empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= csmg_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      word_count_q <= cfg_wdata_i;
    end
  end

  csmg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .crc_o  (push_crc)
  );

  csmg_crc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_crc),
    .pop_i       (pop),
    .pop_data_o  (pop_crc),
    .full_o      (full),
    .empty_o     (empty)
  );

  csmg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_count_i (word_count_q),
    .empty_i      (empty),
    .crc_i        (pop_crc),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

>>> verif/testbench.sv
// testbench for the crc16 seeded mask generator: checks checksum and mask words
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES = 20;
  localparam int unsigned HANG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [csmg_pkg::COUNT_W-1:0] cfg_wdata;

  csmg_in_if in_ch();
  csmg_out_if out_ch();

  crc16_seeded_mask_generator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // predictor state
  logic [15:0] region_crc;
  logic [31:0] gen_lo;
  logic [31:0] gen_hi;
  logic [csmg_pkg::COUNT_W-1:0] words_per_region;
  csmg_pkg::out_word_t expected_words[$];

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // serial crc, one message bit at a time, msb first
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ csmg_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic advance_generator();
    logic [31:0] t;
    t = {gen_hi[0], gen_lo[31:1]} ^ (gen_lo << 12);
    gen_hi = {gen_hi[30:0], gen_lo[0]};
    gen_lo = t ^ (t >> 20);
  endtask

  task automatic predict_byte(input csmg_pkg::in_word_t w);
    csmg_pkg::out_word_t r;
    int unsigned n;
    region_crc = crc16_next(region_crc, w.data_byte);
    if (w.last_byte) begin
      n = (words_per_region > csmg_pkg::MAX_MASK_WORDS) ? csmg_pkg::MAX_MASK_WORDS :
                                                          words_per_region;
      r.kind = csmg_pkg::KIND_CRC;
      r.value = {16'h0000, region_crc};
      r.word_index = '0;
      r.last = (n == 0);
      expected_words.push_back(r);
      gen_lo = {region_crc, region_crc};
      gen_hi = {region_crc, region_crc};
      for (int unsigned i = 0; i < n; i++) begin
        advance_generator();
        r.kind = csmg_pkg::KIND_MASK;
        r.value = gen_lo;
        r.word_index = i[csmg_pkg::COUNT_W-1:0];
        r.last = (i + 1 == n);
        expected_words.push_back(r);
      end
      region_crc = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // predicts on accepted bytes, checks accepted words, drives ready, watches for a hang
  always @(posedge clk) begin : monitor
    csmg_pkg::out_word_t got;
    csmg_pkg::out_word_t want;
    logic any_accept;
    any_accept = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.data);
        any_accept = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        any_accept = 1'b1;
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing pending", got.value, '0);
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind) begin
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
          end
          if (got.value !== want.value) report_mismatch("value", got.value, want.value);
          if (got.word_index !== want.word_index) begin
            report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
          end
          if (got.last !== want.last) begin
            report_mismatch("last", 32'(got.last), 32'(want.last));
          end
        end
      end
    end
    idle_cycles = any_accept ? 0 : idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // entered just after a rising edge; returns just after the edge that takes the byte
  task automatic send_byte(input logic [7:0] b, input logic last_b);
    csmg_pkg::in_word_t w;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    w.data_byte = b;
    w.last_byte = last_b;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_region(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // the count may only change once the block has gone quiet
  task automatic set_word_count(input logic [csmg_pkg::COUNT_W-1:0] cnt);
    in_ch.valid <= 1'b0;
    // let the monitor run first so the last accepted byte is already predicted
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cnt;
    words_per_region = cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_count();
    string check_str;
    check_str = "123456789";
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < check_str.len(); i++) begin
      send_byte(check_str[i], i == check_str.len() - 1);
    end
  endtask

  task automatic test_count_extremes();
    // zero words: only the checksum, marked last
    set_word_count('0);
    send_byte(8'ha5, 1'b1);
    set_word_count(6'd1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h3c, 1'b1);
    set_word_count(csmg_pkg::MAX_MASK_WORDS);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_random_regions(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_bytes);
    int unsigned sent;
    int unsigned len;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int seg = 0; seg < 2; seg++) begin
      set_word_count(csmg_pkg::COUNT_W'($urandom_range(0, 63)));
      sent = 0;
      while (sent < n_bytes / 2) begin
        len = $urandom_range(1, 8);
        send_random_region(len);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    region_crc = '0;
    gen_lo = '0;
    gen_hi = '0;
    words_per_region = csmg_pkg::COUNT_RESET;
    error_count = 0;
    idle_cycles = 0;
    in_idle_pct = 25;
    out_stall_pct = 64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_count();
    test_count_extremes();
    test_random_regions(25, 64, 40);
    test_random_regions(64, 25, 40);
    test_random_regions(0, 0, 40);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
